FILE: sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants for the packed list block
// Action and status codes, cell command bundle, control states, port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int DEPTH_DEFAULT     = 64;
  localparam int WORD_BITS_DEFAULT = 32;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SEARCH,
    CELL_READ
  } cell_op_t;

  typedef struct packed {
    logic     write;
    cell_op_t op;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: sv/pli_in_if.sv
// ----------------------------------------------------------------------------
// pli_in_if: request channel of the packed list
// Valid/ready handshake carrying action, position and data word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_in_if;
  logic                               valid;
  logic                               ready;
  logic [pli_pkg::ACTION_W-1:0]       action;
  logic [pli_pkg::POS_W-1:0]          position;
  logic signed [pli_pkg::DATA_W-1:0]  data_word;

  modport source (output valid, action, position, data_word, input ready);
  modport sink   (input valid, action, position, data_word, output ready);
endinterface

`default_nettype wire

FILE: sv/pli_out_if.sv
// ----------------------------------------------------------------------------
// pli_out_if: response channel of the packed list
// Valid/ready handshake carrying status, found position, read word, count.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_out_if;
  logic                               valid;
  logic                               ready;
  logic [pli_pkg::STATUS_W-1:0]       status;
  logic [pli_pkg::POS_W-1:0]          found_position;
  logic signed [pli_pkg::DATA_W-1:0]  read_word;
  logic [pli_pkg::CNT_W-1:0]          entry_count;

  modport source (output valid, status, found_position, read_word, entry_count, input ready);
  modport sink   (input valid, status, found_position, read_word, entry_count, output ready);
endinterface

`default_nettype wire

FILE: sv/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell: one list entry
// Holds one word, shifts from a neighbor on insert/delete, flags a key or
// position hit for the search tree.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_cell #(
  parameter int INDEX     = 0,
  parameter int CW        = 7,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire pli_pkg::cell_cmd_t    cmd,
  input  wire logic [CW-1:0]         pos,
  input  wire logic [CW-1:0]         count,
  input  wire logic [WORD_BITS-1:0]  key,
  input  wire logic [WORD_BITS-1:0]  left_word,
  input  wire logic [WORD_BITS-1:0]  right_word,
  output logic      [WORD_BITS-1:0]  word,
  output logic                       hit
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      case (cmd.op)
        pli_pkg::CELL_APPEND: begin
          if (IDX == count) word <= key;
        end
        pli_pkg::CELL_INSERT: begin
          if (IDX == pos) word <= key;
          else if (IDX > pos && IDX <= count) word <= left_word;
        end
        pli_pkg::CELL_DELETE: begin
          if (IDX >= pos) word <= right_word;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      pli_pkg::CELL_SEARCH: hit = (word == key) && (IDX < count);
      pli_pkg::CELL_READ:   hit = (IDX == pos);
      default:              hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/pli_tree.sv
// ----------------------------------------------------------------------------
// pli_tree: registered lowest-hit selection tree
// Heap-ordered binary tree, one register level per tree level; each node
// keeps the lower child that hit, with its position and word.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_tree #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic [DEPTH-1:0]            leaf_hit,
  input  wire logic [WORD_BITS-1:0]        leaf_word [DEPTH],
  output logic                             root_hit,
  output logic [$clog2(DEPTH)-1:0]         root_index,
  output logic [WORD_BITS-1:0]             root_word
);

  localparam int LV    = $clog2(DEPTH);
  localparam int P     = 1 << LV;
  localparam int NODES = 2 * P - 1;

  logic                 n_hit  [NODES];
  logic [LV-1:0]        n_idx  [NODES];
  logic [WORD_BITS-1:0] n_word [NODES];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < DEPTH) begin : g_real
      always_ff @(posedge clk) begin
        n_hit[P-1+j]  <= leaf_hit[j];
        n_idx[P-1+j]  <= LV'(j);
        n_word[P-1+j] <= leaf_word[j];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        n_hit[P-1+j]  <= 1'b0;
        n_idx[P-1+j]  <= '0;
        n_word[P-1+j] <= '0;
      end
    end
  end

  // lower child wins when it hit
  for (genvar k = 0; k < P - 1; k++) begin : g_node
    always_ff @(posedge clk) begin
      if (n_hit[2*k+1]) begin
        n_hit[k]  <= 1'b1;
        n_idx[k]  <= n_idx[2*k+1];
        n_word[k] <= n_word[2*k+1];
      end else begin
        n_hit[k]  <= n_hit[2*k+2];
        n_idx[k]  <= n_idx[2*k+2];
        n_word[k] <= n_word[2*k+2];
      end
    end
  end

  assign root_hit   = n_hit[0];
  assign root_index = n_idx[0];
  assign root_word  = n_word[0];

endmodule

`default_nettype wire

FILE: sv/packed_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// packed_list_insert_delete_search: packed list with insert, delete, search
// Append, insert, delete, unknown and rejected requests pass from accept
// to the finish state and then to the output register. Search and in-range
// read first walk the registered tree levels, then pass through finish.
// One request at a time; a held response stalls only the final hand-off.
// Synchronous reset empties the list and sets the capacity to 64; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_list_insert_delete_search #(
  parameter int DEPTH     = pli_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = pli_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [pli_pkg::CNT_W-1:0]   cfg_data,
  pli_in_if.sink                           req,
  pli_out_if.source                        rsp
);

  // Widths: CW holds 0..DEPTH, LV indexes a cell, XW is wide enough to
  // compare position, count and capacity without truncation.
  localparam int LV  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XW  = CW + pli_pkg::CNT_W;
  localparam int WCW = $clog2(LV + 1);
  localparam int PW  = pli_pkg::POS_W;
  localparam int DW  = pli_pkg::DATA_W;

  // Control state
  pli_pkg::state_t              state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [pli_pkg::CNT_W-1:0]    capacity;
  logic [WCW-1:0]               walk;
  logic                         out_valid;

  // Pending result of the item in flight
  pli_pkg::action_t             pend_action;
  pli_pkg::status_t             pend_status;
  logic [PW-1:0]                pend_found;
  logic [DW-1:0]                pend_word;

  // Output register
  logic [pli_pkg::STATUS_W-1:0] out_status;
  logic [PW-1:0]                out_found;
  logic [DW-1:0]                out_word;
  logic [pli_pkg::CNT_W-1:0]    out_count;

  // Request decode
  pli_pkg::action_t             act;
  pli_pkg::cell_cmd_t           cmd;
  pli_pkg::status_t             acc_status;
  logic                         acc_walk;
  logic                         accept;
  logic                         walk_done;
  logic                         out_load;
  logic                         full;

  logic [XW-1:0]                pos_x, cnt_x, cap_x, lim_x, depth_x;
  logic [WORD_BITS+DW-1:0]      key_x;
  logic [WORD_BITS-1:0]         key;

  // Cell row and tree
  logic [WORD_BITS-1:0]         cell_word [DEPTH];
  logic [DEPTH-1:0]             cell_hit;
  logic                         root_hit;
  logic [LV-1:0]                root_index;
  logic [WORD_BITS-1:0]         root_word;
  logic [PW+LV-1:0]             found_x;
  logic [DW+WORD_BITS-1:0]      rd_x;
  logic [pli_pkg::CNT_W+CW-1:0] count_x;

  assign act    = pli_pkg::action_t'(req.action);
  // Take a new word only when idle and out of reset
  assign req.ready = !rst && (state == pli_pkg::ST_IDLE);
  assign accept = req.valid && req.ready;

  // Bring position, count and capacity to one width; capacity above DEPTH
  // acts as DEPTH, and a capacity of zero keeps the list full.
  assign pos_x   = {{(XW - PW){1'b0}}, req.position};
  assign cnt_x   = {{pli_pkg::CNT_W{1'b0}}, count};
  assign lim_x   = {{CW{1'b0}}, capacity};
  assign depth_x = XW'(DEPTH);
  assign cap_x   = (lim_x > depth_x) ? depth_x : lim_x;
  assign full    = (cnt_x >= cap_x);

  // Stored words keep WORD_BITS bits of the sign-extended input word
  assign key_x = {{WORD_BITS{req.data_word[DW-1]}}, req.data_word};
  assign key   = key_x[WORD_BITS-1:0];

  // Root of the tree is valid once the walk counter reaches the tree depth
  assign walk_done = (state == pli_pkg::ST_WALK) && (walk == WCW'(LV));

  always_comb begin
    state_next = state;
    count_next = count;
    cmd.write  = 1'b0;
    cmd.op     = pli_pkg::CELL_HOLD;
    acc_status = pli_pkg::STAT_DONE;
    acc_walk   = 1'b0;
    out_load   = 1'b0;

    // Checks are ordered as the list demands: room first, then position.
    case (act)
      pli_pkg::ACT_APPEND: begin
        cmd.op = pli_pkg::CELL_APPEND;
        if (full) begin
          acc_status = pli_pkg::STAT_FULL;
        end else begin
          cmd.write = accept;
          if (accept) count_next = count + CW'(1);
        end
      end
      pli_pkg::ACT_INSERT: begin
        cmd.op = pli_pkg::CELL_INSERT;
        if (full) begin
          acc_status = pli_pkg::STAT_FULL;
        end else if (pos_x > cnt_x) begin
          acc_status = pli_pkg::STAT_RANGE;
        end else begin
          cmd.write = accept;
          if (accept) count_next = count + CW'(1);
        end
      end
      pli_pkg::ACT_DELETE: begin
        cmd.op = pli_pkg::CELL_DELETE;
        if (pos_x >= cnt_x) begin
          acc_status = pli_pkg::STAT_RANGE;
        end else begin
          cmd.write = accept;
          if (accept) count_next = count - CW'(1);
        end
      end
      pli_pkg::ACT_SEARCH: begin
        cmd.op   = pli_pkg::CELL_SEARCH;
        acc_walk = 1'b1;
      end
      pli_pkg::ACT_READ: begin
        cmd.op = pli_pkg::CELL_READ;
        if (pos_x >= cnt_x) acc_status = pli_pkg::STAT_RANGE;
        else acc_walk = 1'b1;
      end
      default: begin
        // unknown actions change nothing and report done
      end
    endcase

    case (state)
      pli_pkg::ST_IDLE: begin
        if (accept) state_next = acc_walk ? pli_pkg::ST_WALK : pli_pkg::ST_FINISH;
      end
      pli_pkg::ST_WALK: begin
        if (walk_done) state_next = pli_pkg::ST_FINISH;
      end
      pli_pkg::ST_FINISH: begin
        // hand off once the output register is free or being drained
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = pli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pli_pkg::ST_IDLE;
      count     <= '0;
      capacity  <= pli_pkg::CAP_RESET;
      walk      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_load || (out_valid && !rsp.ready);
      if (cfg_write) capacity <= cfg_data;
      if (accept) walk <= '0;
      else if (state == pli_pkg::ST_WALK) walk <= walk + WCW'(1);
    end
  end

  // Search hit gives the lowest matching position; a read hit carries the word
  assign found_x = {{PW{1'b0}}, root_index};
  assign rd_x    = {{DW{root_word[WORD_BITS-1]}}, root_word};
  assign count_x = {{pli_pkg::CNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_action <= act;
      pend_status <= acc_status;
      pend_found  <= '0;
      pend_word   <= '0;
    end else if (walk_done) begin
      if (pend_action == pli_pkg::ACT_SEARCH) begin
        pend_status <= root_hit ? pli_pkg::STAT_DONE : pli_pkg::STAT_MISSING;
        pend_found  <= root_hit ? found_x[PW-1:0] : '0;
      end else begin
        pend_word   <= rd_x[DW-1:0];
      end
    end
    if (out_load) begin
      out_status <= pend_status;
      out_found  <= pend_found;
      out_word   <= pend_word;
      out_count  <= count_x[pli_pkg::CNT_W-1:0];
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_found;
  assign rsp.read_word      = out_word;
  assign rsp.entry_count    = out_count;

  // Row of cells: each takes from its lower neighbor on insert and from its
  // upper neighbor on delete; the ends feed back their own word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_word, right_word;

    if (i == 0) begin : g_first
      assign left_word = cell_word[i];
    end else begin : g_inner_l
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_r
      assign right_word = cell_word[i+1];
    end

    pli_cell #(
      .INDEX     (i),
      .CW        (CW),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_x[CW-1:0]),
      .count      (count),
      .key        (key),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[i]),
      .hit        (cell_hit[i])
    );
  end

  // Lowest hit among the cells, one tree level per cycle
  pli_tree #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_tree (
    .clk        (clk),
    .leaf_hit   (cell_hit),
    .leaf_word  (cell_word),
    .root_hit   (root_hit),
    .root_index (root_index),
    .root_word  (root_word)
  );

endmodule

`default_nettype wire

FILE: sv/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker: port-level checks for the packed list
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [pli_pkg::STATUS_W-1:0]  status,
  input wire logic [pli_pkg::POS_W-1:0]     found_position,
  input wire logic [pli_pkg::DATA_W-1:0]    read_word,
  input wire logic [pli_pkg::CNT_W-1:0]     entry_count
);

  // no response straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // one request at a time: never ready right after taking a word
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken on back-to-back cycles");

  // failed requests carry no position and no word
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != pli_pkg::STAT_DONE) |-> (found_position == '0 && read_word == '0))
    else $error("failed response carries payload");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      ($stable(status) && $stable(found_position) && $stable(read_word) &&
       $stable(entry_count)))
    else $error("response changed while stalled");

endmodule

bind packed_list_insert_delete_search pli_checker u_pli_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .found_position (rsp.found_position),
  .read_word      (rsp.read_word),
  .entry_count    (rsp.entry_count)
);

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for packed_list_insert_delete_search
// Drives a directed table and then random phases of list requests through the
// request channel, re-computes each reply with a local copy of the list, and
// compares every response word field by field. Capacity is changed between
// phases while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;

  // Codes past the last defined action: the block must treat them as no-ops.
  localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  // Search and read walk the tree before replying; give some margin.
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_COUNT    = 9;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  found_position;
    logic [DATA_W-1:0] read_word;
    logic [CNT_W-1:0]  entry_count;
  } list_reply_t;

  // One row of the directed table: either a capacity write or a request,
  // the latter with an optional hand-typed reply.
  typedef struct {
    bit                  is_cfg;
    logic [CNT_W-1:0]    cap_value;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   word;
    bit                  typed;
    list_reply_t         reply;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CNT_W-1:0] cfg_data;

  pli_in_if  req_ch ();
  pli_out_if rsp_ch ();

  packed_list_insert_delete_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Local image of the list, advanced once per accepted request word.
  logic [DATA_W-1:0] list_words [DEPTH_DEFAULT];
  int                list_len;
  logic [CNT_W-1:0]  cap_setting;

  list_reply_t replies_due [$];
  plan_row_t   plan [$];
  int          mismatches;
  int          req_burst;
  int          rsp_burst;
  int          quiet_cycles;
  int          phase_caps [PHASE_COUNT];

  always #1 clk = ~clk;

  // Apply one request to the local list and return the reply it must cause.
  function automatic list_reply_t run_list_op(logic [ACTION_W-1:0] act,
                                              logic [POS_W-1:0] pos,
                                              logic [DATA_W-1:0] word);
    list_reply_t r;
    int          room;
    int          i;
    r = '0;
    r.status = STAT_DONE;
    // A capacity above the store depth counts as the full depth.
    room = (cap_setting > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(cap_setting);
    case (act)
      ACT_APPEND: begin
        if (list_len >= room) r.status = STAT_FULL;
        else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      ACT_INSERT: begin
        // Full wins over a bad position.
        if (list_len >= room) r.status = STAT_FULL;
        else if (pos > list_len) r.status = STAT_RANGE;
        else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_len) r.status = STAT_RANGE;
        else begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ACT_SEARCH: begin
        // Keep the lowest hit only.
        r.status = STAT_MISSING;
        for (i = 0; i < list_len; i++) begin
          if (r.status == STAT_MISSING && list_words[i] == word) begin
            r.status = STAT_DONE;
            r.found_position = POS_W'(i);
          end
        end
      end
      ACT_READ: begin
        if (pos >= list_len) r.status = STAT_RANGE;
        else r.read_word = list_words[pos];
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_W'(list_len);
    return r;
  endfunction

  function automatic void plan_cfg(logic [CNT_W-1:0] value);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cap_value = value;
    plan.push_back(row);
  endfunction

  function automatic void plan_req(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] word);
    plan_row_t row;
    row = '{default: '0};
    row.act = act;
    row.pos = pos;
    row.word = word;
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                     logic [DATA_W-1:0] word, status_t st,
                                     logic [POS_W-1:0] found, logic [DATA_W-1:0] rd,
                                     logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row = '{default: '0};
    row.act = act;
    row.pos = pos;
    row.word = word;
    row.typed = 1'b1;
    row.reply.status = st;
    row.reply.found_position = found;
    row.reply.read_word = rd;
    row.reply.entry_count = cnt;
    plan.push_back(row);
  endfunction

  // Hold one request word on the channel until it is taken, then record the
  // reply it is owed. Valid stays high across back-to-back words.
  task automatic send_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] word, bit typed,
                              list_reply_t typed_reply);
    int          gap;
    list_reply_t due;
    if (req_burst > 0) begin
      gap = 0;
      req_burst--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = 0;
      req_burst = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 4);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.position  <= pos;
    req_ch.data_word <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    due = run_list_op(act, pos, word);
    replies_due.push_back(typed ? typed_reply : due);
  endtask

  // Change the capacity only with the block idle: drop valid, wait for all
  // owed replies, let the pipeline settle, then write.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    cap_setting = value;
  endtask

  // Stimulus.
  initial begin
    int                  phase;
    int                  k;
    int                  span;
    int                  pick;
    bit                  grow;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   word;

    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = CAP_RESET;
    req_ch.valid = 1'b0;
    req_ch.action = '0;
    req_ch.position = '0;
    req_ch.data_word = '0;
    rsp_ch.ready = 1'b0;
    cap_setting = CAP_RESET;
    list_len = 0;
    mismatches = 0;
    req_burst = 0;
    rsp_burst = 0;
    for (k = 0; k < DEPTH_DEFAULT; k++) list_words[k] = '0;

    // Empty list: every positional request is out of range, search misses.
    plan_typed(ACT_READ,   6'd0, '0, STAT_RANGE,   '0, '0, 7'd0);
    plan_typed(ACT_DELETE, 6'd0, '0, STAT_RANGE,   '0, '0, 7'd0);
    plan_typed(ACT_SEARCH, 6'd0, '0, STAT_MISSING, '0, '0, 7'd0);
    plan_typed(ACT_INSERT, 6'd1, 32'd5, STAT_RANGE, '0, '0, 7'd0);
    // Extreme words in and back out.
    plan_typed(ACT_APPEND, 6'd0, WORD_MAX, STAT_DONE, '0, '0, 7'd1);
    plan_typed(ACT_APPEND, 6'd0, WORD_MIN, STAT_DONE, '0, '0, 7'd2);
    plan_typed(ACT_READ,   6'd0, '0, STAT_DONE, '0, WORD_MAX, 7'd2);
    plan_typed(ACT_READ,   6'd1, '0, STAT_DONE, '0, WORD_MIN, 7'd2);
    // Insert at the head and at the very end, then at position 63, past the end.
    plan_req(ACT_INSERT, 6'd0, WORD_ONES);
    plan_req(ACT_INSERT, 6'd3, '0);
    plan_typed(ACT_INSERT, 6'd63, 32'd9, STAT_RANGE, '0, '0, 7'd4);
    // Duplicate key: search must report the lowest position.
    plan_req(ACT_SEARCH, 6'd0, WORD_MIN);
    plan_req(ACT_APPEND, 6'd0, WORD_ONES);
    plan_req(ACT_SEARCH, 6'd63, WORD_ONES);
    plan_req(ACT_SEARCH, 6'd0, 32'd12345);
    plan_typed(ACT_READ,   6'd63, '0, STAT_RANGE, '0, '0, 7'd5);
    // Delete head and tail, then out of range.
    plan_req(ACT_DELETE, 6'd0, '0);
    plan_req(ACT_DELETE, 6'd3, '0);
    plan_typed(ACT_DELETE, 6'd63, '0, STAT_RANGE, '0, '0, 7'd3);
    // Undefined action codes do nothing.
    plan_typed(ACT_UNUSED_FIRST, 6'd63, WORD_ONES, STAT_DONE, '0, '0, 7'd3);
    plan_typed(ACT_UNUSED_LAST,  6'd0,  WORD_MAX,  STAT_DONE, '0, '0, 7'd3);
    // Capacity below the live count: nothing dropped, growth reports full,
    // full is reported ahead of a bad position.
    plan_cfg(7'd1);
    plan_typed(ACT_APPEND, 6'd0,  32'd1, STAT_FULL, '0, '0, 7'd3);
    plan_typed(ACT_INSERT, 6'd63, 32'd1, STAT_FULL, '0, '0, 7'd3);
    plan_req(ACT_SEARCH, 6'd0, '0);
    plan_req(ACT_READ,   6'd2, '0);
    // Zero capacity: always full.
    plan_cfg(7'd0);
    plan_typed(ACT_INSERT, 6'd0, 32'd5, STAT_FULL, '0, '0, 7'd3);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_capacity(plan[k].cap_value);
      else send_request(plan[k].act, plan[k].pos, plan[k].word,
                        plan[k].typed, plan[k].reply);
    end

    // Random phases, each at its own capacity; above-depth and zero included.
    phase_caps = '{64, 8, 1, 127, 0, 0, 64, 0, 2};
    phase_caps[5] = $urandom_range(1, 64);
    phase_caps[7] = $urandom_range(1, 64);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      write_capacity(CNT_W'(phase_caps[phase]));
      span = (phase_caps[phase] >= DEPTH_DEFAULT) ? 160 : 90;
      for (k = 0; k < span; k++) begin
        // Fill during the first part of a phase, drain during the rest.
        grow = (k < (span * 6) / 10);
        pick = $urandom_range(0, 99);
        if (grow) begin
          if (pick < 45) act = ACT_APPEND;
          else if (pick < 80) act = ACT_INSERT;
          else if (pick < 86) act = ACT_DELETE;
          else if (pick < 93) act = ACT_SEARCH;
          else if (pick < 98) act = ACT_READ;
          else act = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        end else begin
          if (pick < 10) act = ACT_APPEND;
          else if (pick < 20) act = ACT_INSERT;
          else if (pick < 60) act = ACT_DELETE;
          else if (pick < 78) act = ACT_SEARCH;
          else if (pick < 97) act = ACT_READ;
          else act = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        end

        // Positions mostly legal for the current count, sometimes anywhere.
        pos = POS_W'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 85) begin
          if (act == ACT_INSERT) pos = POS_W'($urandom_range(0, list_len));
          else if ((act == ACT_DELETE || act == ACT_READ) && list_len > 0)
            pos = POS_W'($urandom_range(0, list_len - 1));
        end

        // Words: mostly random, some from a small set to force duplicates;
        // search keys mostly taken from the live list.
        word = $urandom;
        pick = $urandom_range(0, 99);
        if (act == ACT_SEARCH && list_len > 0 && pick < 70) begin
          word = list_words[$urandom_range(0, list_len - 1)];
        end else if (pick < 20) begin
          case ($urandom_range(0, 4))
            0: word = WORD_MAX;
            1: word = WORD_MIN;
            2: word = WORD_ONES;
            3: word = '0;
            default: word = DATA_W'($urandom_range(1, 3));
          endcase
        end

        send_request(act, pos, word, 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Response side: stall ready at random, check each word taken.
  initial begin
    int          stall;
    list_reply_t want;
    while (rst) @(posedge clk);
    forever begin
      if (rsp_burst > 0) begin
        stall = 0;
        rsp_burst--;
      end else if ($urandom_range(0, 19) == 0) begin
        stall = 0;
        rsp_burst = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);

      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response, expected none actual status %0d count %0d",
                 $time, rsp_ch.status, rsp_ch.entry_count);
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp_ch.status);
        end
        if (rsp_ch.found_position !== want.found_position) begin
          mismatches++;
          $display("%0t: found_position expected %0d actual %0d",
                   $time, want.found_position, rsp_ch.found_position);
        end
        if (rsp_ch.read_word !== want.read_word) begin
          mismatches++;
          $display("%0t: read_word expected %0d actual %0d",
                   $time, $signed(want.read_word), rsp_ch.read_word);
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          mismatches++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, rsp_ch.entry_count);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: timeout, %0d replies outstanding", $time, replies_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
